[sv/skinning_palette_builder_defines.svh]
// Assertion macros for the skinning palette builder.
`ifndef SKINNING_PALETTE_BUILDER_DEFINES_SVH
`define SKINNING_PALETTE_BUILDER_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication check.
`define SPB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spb check failed");

// Next-cycle implication check.
`define SPB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spb check failed");

`else

`define SPB_ASSERT_NOW(label, clk, rst, ante, cons)
`define SPB_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[sv/spb_pkg.sv]
package spb_pkg;

   localparam int MAX_JOINTS = 64;
   localparam int FRAC_BITS  = 16;

   localparam int JOINT_AW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
   localparam int IB_AW    = JOINT_AW + 2;
   localparam int GM_AW    = JOINT_AW + 2;

   // Wide enough for four rounded products and for the rotation sums.
   localparam int ACC_W = 52;
   localparam int QP_W  = 48;

   localparam logic signed [31:0] ONE_Q  = 32'(64'sd1 <<< FRAC_BITS);
   localparam logic signed [63:0] HALF_Q = 64'sd1 <<< (FRAC_BITS - 1);

   typedef enum logic [1:0] {
      CMD_LOAD_IB    = 2'd0,
      CMD_LOAD_SCALE = 2'd1,
      CMD_POSE       = 2'd2,
      CMD_UNUSED     = 2'd3
   } cmd_type;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_QUAT  = 7'b0000010,
      ST_ROT   = 7'b0000100,
      ST_LOCAL = 7'b0001000,
      ST_GLOB  = 7'b0010000,
      ST_SKIN  = 7'b0100000,
      ST_EMIT  = 7'b1000000
   } state_type;

   // Tag that follows a product through the multiplier register.
   typedef struct packed {
      logic       vld;
      logic       first;
      logic       last;
      logic [3:0] idx;
   } tag_type;

endpackage

[sv/skinning_palette_builder.sv]
// Skinning palette builder, signed Q16.16 fixed point.
// Input channel req_*: one command per transfer. Load inverse-bind row and
// load scale are stored on acceptance and give no result. Pose joint builds
// T*R*S, multiplies by the parent's stored global matrix (unless root),
// stores the new global matrix and returns global * inverse-bind as four
// row transfers on rsp_*, rows 0..3, rsp_last on row 3.
// A pose runs on one shared 32x32 multiplier with a one-stage product
// register and a rounding accumulator: 9 quaternion products, 12 local
// products, 48 parent products and 64 skin products, plus phase changes.
// No new item is taken before the last row of a pose has gone out.
// req_ready is high only while the block is idle; the four rows then go
// out at one per cycle as long as rsp_ready is high. A stalled receiver
// holds the current row and the block waits; no item is taken meanwhile.
// Synchronous reset returns the sequencer to idle. The joint stores are
// not cleared: entries read before they are written are undefined.
// Joint indices at or above the joint count and the unused command are
// accepted and dropped.
`include "skinning_palette_builder_defines.svh"

module skinning_palette_builder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_command,
   input  logic [5:0]         req_joint,
   input  logic signed [6:0]  req_parent,
   input  logic [1:0]         req_row,
   input  logic signed [31:0] req_data_a,
   input  logic signed [31:0] req_data_b,
   input  logic signed [31:0] req_data_c,
   input  logic signed [31:0] req_data_d,
   input  logic signed [31:0] req_trans_x,
   input  logic signed [31:0] req_trans_y,
   input  logic signed [31:0] req_trans_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_out_row,
   output logic signed [31:0] rsp_elem_0,
   output logic signed [31:0] rsp_elem_1,
   output logic signed [31:0] rsp_elem_2,
   output logic signed [31:0] rsp_elem_3,
   output logic               rsp_order_error,
   output logic               rsp_saturated,
   output logic               rsp_last
);

   // Saturate to 32 bits, flag in the top bit.
   function automatic logic [32:0] sat32(input logic signed [spb_pkg::ACC_W-1:0] v);
      logic [32:0] res;
      if (v > spb_pkg::ACC_W'(64'sd2147483647)) begin
         res = {1'b1, 32'h7fffffff};
      end else if (v < -spb_pkg::ACC_W'(64'sd2147483648)) begin
         res = {1'b1, 32'h80000000};
      end else begin
         res = {1'b0, v[31:0]};
      end
      return res;
   endfunction

   // Memories
   logic [127:0] ib_mem [spb_pkg::MAX_JOINTS*4];
   logic [95:0]  sc_mem [spb_pkg::MAX_JOINTS];
   logic [127:0] gm_mem [spb_pkg::MAX_JOINTS*3];

   logic [127:0] ib_rd_ff;
   logic [95:0]  sc_rd_ff;
   logic [127:0] gm_rd_ff;

   // Control
   spb_pkg::state_type state_ff, state_in;
   logic [6:0]         cnt_ff, cnt_in;
   logic [1:0]         er_ff, er_in;
   logic [2:0]         rd_idx_ff;
   logic               rd_vld_ff;

   // Per-pose registers
   logic [spb_pkg::JOINT_AW-1:0] j_ff;
   logic [spb_pkg::GM_AW-1:0]    j3_ff, p3_ff;
   logic                         root_ff, err_ff, jsat_ff;
   logic [3:0]                   rowflag_ff;
   logic signed [31:0]           q_ff [4];
   logic signed [31:0]           trans_ff [3];
   logic signed [31:0]           sc_ff [3];
   logic signed [spb_pkg::QP_W-1:0] qp_ff [9];
   logic signed [31:0]           rot_ff [3][3];
   logic signed [31:0]           loc_ff [3][4];
   logic signed [31:0]           par_ff [3][4];
   logic signed [31:0]           glob_ff [3][4];
   logic signed [31:0]           ib_ff [4][4];
   logic signed [31:0]           skin_ff [4][4];

   // Shared multiplier and accumulator
   logic signed [31:0]              op_a, op_b;
   spb_pkg::tag_type                tag_in, tag_ff;
   logic signed [63:0]              prod_ff;
   logic signed [spb_pkg::ACC_W-1:0] acc_ff;
   logic signed [63:0]              rnd64;
   logic signed [spb_pkg::ACC_W-1:0] sum;
   logic [32:0]                     sat_res;

   logic       req_fire, in_range;
   logic [6:0] phase_len;
   logic [1:0] cr, cc, ck;

   assign req_ready = (state_ff == spb_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign in_range  = (int'(req_joint) < spb_pkg::MAX_JOINTS);

   assign cr = cnt_ff[5:4];
   assign cc = cnt_ff[3:2];
   assign ck = cnt_ff[1:0];

   // Number of products issued per phase
   always_comb begin
      unique case (state_ff)
         spb_pkg::ST_QUAT:  phase_len = 7'd9;
         spb_pkg::ST_LOCAL: phase_len = 7'd12;
         spb_pkg::ST_GLOB:  phase_len = 7'd48;
         spb_pkg::ST_SKIN:  phase_len = 7'd64;
         default:           phase_len = 7'd0;
      endcase
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      er_in    = er_ff;
      unique case (state_ff)
         spb_pkg::ST_IDLE: begin
            if (req_fire && in_range && (req_command == spb_pkg::CMD_POSE)) begin
               state_in = spb_pkg::ST_QUAT;
               cnt_in   = '0;
            end
         end
         spb_pkg::ST_ROT: begin
            state_in = spb_pkg::ST_LOCAL;
            cnt_in   = '0;
         end
         spb_pkg::ST_EMIT: begin
            if (rsp_ready) begin
               er_in = er_ff + 2'd1;
               if (er_ff == 2'd3) begin
                  state_in = spb_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            // multiply phases: issue, then wait for the last write-back
            if (cnt_ff == phase_len) begin
               cnt_in = '0;
               unique case (state_ff)
                  spb_pkg::ST_QUAT:  state_in = spb_pkg::ST_ROT;
                  spb_pkg::ST_LOCAL: state_in = spb_pkg::ST_GLOB;
                  spb_pkg::ST_GLOB:  state_in = spb_pkg::ST_SKIN;
                  default: begin
                     state_in = spb_pkg::ST_EMIT;
                     er_in    = '0;
                  end
               endcase
            end else begin
               cnt_in = cnt_ff + 7'd1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= spb_pkg::ST_IDLE;
         cnt_ff    <= '0;
         er_ff     <= '0;
         tag_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         er_ff     <= er_in;
         tag_ff    <= tag_in;
         rd_vld_ff <= (state_ff == spb_pkg::ST_QUAT) && (cnt_ff < 7'd4);
      end
   end

   // Operand select for the shared multiplier
   always_comb begin
      op_a   = '0;
      op_b   = '0;
      tag_in = '0;
      unique case (state_ff)
         spb_pkg::ST_QUAT: begin
            tag_in = '{vld: cnt_ff < phase_len, first: 1'b1, last: 1'b1, idx: cnt_ff[3:0]};
            unique case (cnt_ff[3:0])
               4'd0:    begin op_a = q_ff[0]; op_b = q_ff[0]; end
               4'd1:    begin op_a = q_ff[1]; op_b = q_ff[1]; end
               4'd2:    begin op_a = q_ff[2]; op_b = q_ff[2]; end
               4'd3:    begin op_a = q_ff[0]; op_b = q_ff[1]; end
               4'd4:    begin op_a = q_ff[0]; op_b = q_ff[2]; end
               4'd5:    begin op_a = q_ff[1]; op_b = q_ff[2]; end
               4'd6:    begin op_a = q_ff[3]; op_b = q_ff[0]; end
               4'd7:    begin op_a = q_ff[3]; op_b = q_ff[1]; end
               4'd8:    begin op_a = q_ff[3]; op_b = q_ff[2]; end
               default: begin op_a = '0;      op_b = '0;      end
            endcase
         end
         spb_pkg::ST_LOCAL: begin
            // column 3 passes the translation through a multiply by one
            tag_in = '{vld: cnt_ff < phase_len, first: 1'b1, last: 1'b1, idx: cnt_ff[3:0]};
            if (cnt_ff[1:0] == 2'd3) begin
               op_a = trans_ff[cnt_ff[3:2]];
               op_b = spb_pkg::ONE_Q;
            end else begin
               op_a = rot_ff[cnt_ff[3:2]][cnt_ff[1:0]];
               op_b = sc_ff[cnt_ff[1:0]];
            end
         end
         spb_pkg::ST_GLOB: begin
            tag_in = '{vld: cnt_ff < phase_len, first: ck == 2'd0, last: ck == 2'd3,
                       idx: cnt_ff[5:2]};
            op_a = par_ff[cr][ck];
            if (ck == 2'd3) begin
               op_b = (cc == 2'd3) ? spb_pkg::ONE_Q : 32'sd0;
            end else begin
               op_b = loc_ff[ck][cc];
            end
         end
         spb_pkg::ST_SKIN: begin
            tag_in = '{vld: cnt_ff < phase_len, first: ck == 2'd0, last: ck == 2'd3,
                       idx: cnt_ff[5:2]};
            op_b = ib_ff[ck][cc];
            if (cr == 2'd3) begin
               op_a = (ck == 2'd3) ? spb_pkg::ONE_Q : 32'sd0;
            end else begin
               op_a = glob_ff[cr][ck];
            end
         end
         default: begin
            tag_in = '0;
         end
      endcase
   end

   // Product register
   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   // Round, accumulate, saturate
   assign rnd64   = (prod_ff + spb_pkg::HALF_Q) >>> spb_pkg::FRAC_BITS;
   assign sum     = (tag_ff.first ? '0 : acc_ff) + spb_pkg::ACC_W'(rnd64);
   assign sat_res = sat32(sum);

   // Memory ports
   always_ff @(posedge clock) begin
      if (req_fire && in_range && (req_command == spb_pkg::CMD_LOAD_IB)) begin
         ib_mem[{spb_pkg::JOINT_AW'(req_joint), req_row}] <=
            {req_data_d, req_data_c, req_data_b, req_data_a};
      end
      if (req_fire && in_range && (req_command == spb_pkg::CMD_LOAD_SCALE)) begin
         sc_mem[spb_pkg::JOINT_AW'(req_joint)] <= {req_data_c, req_data_b, req_data_a};
      end
      if ((state_ff == spb_pkg::ST_SKIN) && (cnt_ff < 7'd3)) begin
         gm_mem[j3_ff + spb_pkg::GM_AW'(cnt_ff[1:0])] <=
            {glob_ff[cnt_ff[1:0]][3], glob_ff[cnt_ff[1:0]][2],
             glob_ff[cnt_ff[1:0]][1], glob_ff[cnt_ff[1:0]][0]};
      end
      ib_rd_ff <= ib_mem[{j_ff, cnt_ff[1:0]}];
      sc_rd_ff <= sc_mem[j_ff];
      gm_rd_ff <= gm_mem[p3_ff + spb_pkg::GM_AW'(cnt_ff[1:0])];
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      logic [32:0] s;
      logic        rsat;
      logic signed [spb_pkg::ACC_W-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz, one;

      xx  = spb_pkg::ACC_W'(qp_ff[0]);
      yy  = spb_pkg::ACC_W'(qp_ff[1]);
      zz  = spb_pkg::ACC_W'(qp_ff[2]);
      xy  = spb_pkg::ACC_W'(qp_ff[3]);
      xz  = spb_pkg::ACC_W'(qp_ff[4]);
      yz  = spb_pkg::ACC_W'(qp_ff[5]);
      wx  = spb_pkg::ACC_W'(qp_ff[6]);
      wy  = spb_pkg::ACC_W'(qp_ff[7]);
      wz  = spb_pkg::ACC_W'(qp_ff[8]);
      one = spb_pkg::ACC_W'(spb_pkg::ONE_Q);

      // capture an accepted command; a pose uses these fields
      if (req_fire) begin
         j_ff        <= spb_pkg::JOINT_AW'(req_joint);
         j3_ff       <= spb_pkg::GM_AW'({req_joint, 1'b0}) + spb_pkg::GM_AW'(req_joint);
         p3_ff       <= spb_pkg::GM_AW'({req_parent[5:0], 1'b0}) +
                        spb_pkg::GM_AW'(req_parent[5:0]);
         root_ff     <= req_parent[6] || (req_parent[5:0] >= req_joint);
         err_ff      <= !req_parent[6] && (req_parent[5:0] >= req_joint);
         jsat_ff     <= 1'b0;
         rowflag_ff  <= '0;
         q_ff[0]     <= req_data_a;
         q_ff[1]     <= req_data_b;
         q_ff[2]     <= req_data_c;
         q_ff[3]     <= req_data_d;
         trans_ff[0] <= req_trans_x;
         trans_ff[1] <= req_trans_y;
         trans_ff[2] <= req_trans_z;
      end

      // load stored operands; a root takes the identity as parent
      rd_idx_ff <= cnt_ff[2:0];
      if (rd_vld_ff) begin
         ib_ff[rd_idx_ff[1:0]][0] <= ib_rd_ff[31:0];
         ib_ff[rd_idx_ff[1:0]][1] <= ib_rd_ff[63:32];
         ib_ff[rd_idx_ff[1:0]][2] <= ib_rd_ff[95:64];
         ib_ff[rd_idx_ff[1:0]][3] <= ib_rd_ff[127:96];
         if (rd_idx_ff == 3'd0) begin
            sc_ff[0] <= sc_rd_ff[31:0];
            sc_ff[1] <= sc_rd_ff[63:32];
            sc_ff[2] <= sc_rd_ff[95:64];
         end
         if (rd_idx_ff < 3'd3) begin
            for (int c = 0; c < 4; c++) begin
               if (root_ff) begin
                  par_ff[rd_idx_ff[1:0]][c] <=
                     (c == int'(rd_idx_ff)) ? spb_pkg::ONE_Q : 32'sd0;
               end else begin
                  par_ff[rd_idx_ff[1:0]][c] <= gm_rd_ff[c*32 +: 32];
               end
            end
         end
      end

      // rotation from the quaternion products
      if (state_ff == spb_pkg::ST_ROT) begin
         rsat = 1'b0;
         s = sat32(one - 2 * (yy + zz)); rot_ff[0][0] <= s[31:0];
         rsat = rsat | s[32];
         s = sat32(2 * (xy - wz));       rot_ff[0][1] <= s[31:0];
         rsat = rsat | s[32];
         s = sat32(2 * (xz + wy));       rot_ff[0][2] <= s[31:0];
         rsat = rsat | s[32];
         s = sat32(2 * (xy + wz));       rot_ff[1][0] <= s[31:0];
         rsat = rsat | s[32];
         s = sat32(one - 2 * (xx + zz)); rot_ff[1][1] <= s[31:0];
         rsat = rsat | s[32];
         s = sat32(2 * (yz - wx));       rot_ff[1][2] <= s[31:0];
         rsat = rsat | s[32];
         s = sat32(2 * (xz - wy));       rot_ff[2][0] <= s[31:0];
         rsat = rsat | s[32];
         s = sat32(2 * (yz + wx));       rot_ff[2][1] <= s[31:0];
         rsat = rsat | s[32];
         s = sat32(one - 2 * (xx + yy)); rot_ff[2][2] <= s[31:0];
         rsat = rsat | s[32];
         if (rsat) jsat_ff <= 1'b1;
      end

      // accumulator write-back
      if (tag_ff.vld) begin
         acc_ff <= sum;
         if (tag_ff.last) begin
            unique case (state_ff)
               spb_pkg::ST_QUAT: begin
                  qp_ff[tag_ff.idx] <= sum[spb_pkg::QP_W-1:0];
               end
               spb_pkg::ST_LOCAL: begin
                  loc_ff[tag_ff.idx[3:2]][tag_ff.idx[1:0]] <= sat_res[31:0];
                  if (sat_res[32]) jsat_ff <= 1'b1;
               end
               spb_pkg::ST_GLOB: begin
                  glob_ff[tag_ff.idx[3:2]][tag_ff.idx[1:0]] <= sat_res[31:0];
                  if (sat_res[32]) jsat_ff <= 1'b1;
               end
               spb_pkg::ST_SKIN: begin
                  skin_ff[tag_ff.idx[3:2]][tag_ff.idx[1:0]] <= sat_res[31:0];
                  if (sat_res[32]) rowflag_ff[tag_ff.idx[3:2]] <= 1'b1;
               end
               default: ;
            endcase
         end
      end
   end

   // Result rows
   assign rsp_valid       = (state_ff == spb_pkg::ST_EMIT);
   assign rsp_out_row     = er_ff;
   assign rsp_elem_0      = skin_ff[er_ff][0];
   assign rsp_elem_1      = skin_ff[er_ff][1];
   assign rsp_elem_2      = skin_ff[er_ff][2];
   assign rsp_elem_3      = skin_ff[er_ff][3];
   assign rsp_order_error = err_ff;
   assign rsp_saturated   = rowflag_ff[er_ff] || jsat_ff;
   assign rsp_last        = (er_ff == 2'd3);

   // Checks
   `SPB_ASSERT_NOW(a_rsp_blocks_req, clock, reset, rsp_valid, !req_ready)
   `SPB_ASSERT_NEXT(a_rows_continue, clock, reset, rsp_valid && rsp_ready && !rsp_last, rsp_valid)
   `SPB_ASSERT_NEXT(a_last_frees, clock, reset, rsp_valid && rsp_ready && rsp_last, req_ready)
   `SPB_ASSERT_NOW(a_tag_busy, clock, reset, tag_ff.vld, !req_ready && !rsp_valid)

endmodule

[test/skinning_palette_builder_test.sv]
`timescale 1ns / 100ps

module skinning_palette_builder_test;

   typedef int mat_type[4][4];

   typedef struct {
      spb_pkg::cmd_type   cmd;
      logic [5:0]         joint;
      logic signed [6:0]  parent;
      logic [1:0]         row;
      logic signed [31:0] d[4];
      logic signed [31:0] t[3];
   } command_type;

   typedef struct {
      logic [1:0] out_row;
      int         elem[4];
      bit         order_error;
      bit         saturated;
      bit         last;
   } palette_row_type;

   // Joint state mirror and queue of skinning rows still due
   class palette_scoreboard;
      int ib_mem[64][16];
      int scale_mem[64][3];
      int global_mem[64][12];
      palette_row_type rows_due[$];
      int mismatches = 0;
      int rows_checked = 0;
      int poses = 0;

      task report(string what, longint got, longint want);
         $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
         mismatches++;
      endtask

      // Q16.16 product rounded half up with floor shift
      function longint qmul(int a, int b);
         longint p;
         p = longint'(a) * longint'(b) + 64'sd32768;
         return p >>> spb_pkg::FRAC_BITS;
      endfunction

      function int clamp(longint v, inout bit f);
         if (v > 64'sd2147483647) begin
            f = 1;
            return 32'sh7fffffff;
         end
         if (v < -64'sd2147483648) begin
            f = 1;
            return 32'sh80000000;
         end
         return int'(v);
      endfunction

      function void mat_product(input mat_type a, input mat_type b, output mat_type c,
                                output bit rf[4]);
         longint acc;
         for (int r = 0; r < 4; r++) begin
            rf[r] = 0;
            for (int j = 0; j < 4; j++) begin
               acc = 0;
               for (int k = 0; k < 4; k++) acc += qmul(a[r][k], b[k][j]);
               c[r][j] = clamp(acc, rf[r]);
            end
         end
      endfunction

      function void note_command(command_type c);
         int j;
         int x, y, z, w;
         longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
         longint one;
         int rot[3][3];
         mat_type loc, par_m, glob, ib, skin;
         bit rf[4], pf[4];
         bit jsat, err, root;
         palette_row_type pr;
         j = c.joint;
         one = longint'(spb_pkg::ONE_Q);
         case (c.cmd)
            spb_pkg::CMD_LOAD_IB: begin
               for (int i = 0; i < 4; i++) ib_mem[j][c.row*4+i] = c.d[i];
               return;
            end
            spb_pkg::CMD_LOAD_SCALE: begin
               for (int i = 0; i < 3; i++) scale_mem[j][i] = c.d[i];
               return;
            end
            spb_pkg::CMD_POSE: ;
            default: return;
         endcase
         poses++;
         jsat = 0;
         x = c.d[0]; y = c.d[1]; z = c.d[2]; w = c.d[3];
         xx = qmul(x, x); yy = qmul(y, y); zz = qmul(z, z);
         xy = qmul(x, y); xz = qmul(x, z); yz = qmul(y, z);
         wx = qmul(w, x); wy = qmul(w, y); wz = qmul(w, z);
         rot[0][0] = clamp(one - 2*(yy+zz), jsat);
         rot[0][1] = clamp(2*(xy-wz), jsat);
         rot[0][2] = clamp(2*(xz+wy), jsat);
         rot[1][0] = clamp(2*(xy+wz), jsat);
         rot[1][1] = clamp(one - 2*(xx+zz), jsat);
         rot[1][2] = clamp(2*(yz-wx), jsat);
         rot[2][0] = clamp(2*(xz-wy), jsat);
         rot[2][1] = clamp(2*(yz+wx), jsat);
         rot[2][2] = clamp(one - 2*(xx+yy), jsat);
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++)
               loc[r][k] = clamp(qmul(rot[r][k], scale_mem[j][k]), jsat);
            loc[r][3] = c.t[r];
         end
         loc[3] = '{0, 0, 0, int'(spb_pkg::ONE_Q)};
         // Out-of-order parent falls back to root with the error flag
         err = 0;
         root = c.parent < 0;
         if (!root && int'(c.parent) >= j) begin
            err = 1;
            root = 1;
         end
         if (root) glob = loc;
         else begin
            for (int r = 0; r < 3; r++)
               for (int k = 0; k < 4; k++) par_m[r][k] = global_mem[c.parent][r*4+k];
            par_m[3] = '{0, 0, 0, int'(spb_pkg::ONE_Q)};
            mat_product(par_m, loc, glob, pf);
            for (int r = 0; r < 4; r++) if (pf[r]) jsat = 1;
         end
         glob[3] = '{0, 0, 0, int'(spb_pkg::ONE_Q)};
         for (int r = 0; r < 3; r++)
            for (int k = 0; k < 4; k++) global_mem[j][r*4+k] = glob[r][k];
         for (int r = 0; r < 4; r++)
            for (int k = 0; k < 4; k++) ib[r][k] = ib_mem[j][r*4+k];
         mat_product(glob, ib, skin, rf);
         for (int r = 0; r < 4; r++) begin
            pr.out_row = 2'(r);
            for (int k = 0; k < 4; k++) pr.elem[k] = skin[r][k];
            pr.order_error = err;
            pr.saturated = rf[r] | jsat;
            pr.last = (r == 3);
            rows_due.push_back(pr);
         end
      endfunction

      task check_row(palette_row_type got);
         palette_row_type want;
         if (rows_due.size() == 0) begin
            report("unexpected row", got.out_row, -1);
            return;
         end
         want = rows_due.pop_front();
         rows_checked++;
         if (got.out_row !== want.out_row) report("out_row", got.out_row, want.out_row);
         for (int k = 0; k < 4; k++)
            if (got.elem[k] !== want.elem[k])
               report($sformatf("elem_%0d row %0d", k, want.out_row), got.elem[k],
                      want.elem[k]);
         if (got.order_error !== want.order_error)
            report("order_error", got.order_error, want.order_error);
         if (got.saturated !== want.saturated)
            report("saturated", got.saturated, want.saturated);
         if (got.last !== want.last) report("last", got.last, want.last);
      endtask
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   logic [1:0]         req_command = '0;
   logic [5:0]         req_joint = '0;
   logic signed [6:0]  req_parent = '0;
   logic [1:0]         req_row = '0;
   logic signed [31:0] req_data_a = '0, req_data_b = '0, req_data_c = '0, req_data_d = '0;
   logic signed [31:0] req_trans_x = '0, req_trans_y = '0, req_trans_z = '0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic [1:0]         rsp_out_row;
   logic signed [31:0] rsp_elem_0, rsp_elem_1, rsp_elem_2, rsp_elem_3;
   logic               rsp_order_error, rsp_saturated, rsp_last;

   palette_scoreboard sb = new();

   // Host-side record of what has been written, so no unwritten entry is read
   bit [3:0] ib_loaded[64];
   bit       scale_loaded[64];
   bit       posed[64];
   int       sent = 0;
   int       burst_left = 0;

   skinning_palette_builder i_dut (.*);

   always #5 clock = ~clock;

   // Sender: drive one command, hold until transfer, then maybe idle
   task send(command_type c);
      req_valid   <= 1;
      req_command <= c.cmd;
      req_joint   <= c.joint;
      req_parent  <= c.parent;
      req_row     <= c.row;
      req_data_a  <= c.d[0];
      req_data_b  <= c.d[1];
      req_data_c  <= c.d[2];
      req_data_d  <= c.d[3];
      req_trans_x <= c.t[0];
      req_trans_y <= c.t[1];
      req_trans_z <= c.t[2];
      do @(posedge clock); while (!req_ready);
      sb.note_command(c);
      sent++;
      case (c.cmd)
         spb_pkg::CMD_LOAD_IB:    ib_loaded[c.joint][c.row] = 1;
         spb_pkg::CMD_LOAD_SCALE: scale_loaded[c.joint] = 1;
         spb_pkg::CMD_POSE:       posed[c.joint] = 1;
         default: ;
      endcase
      if (burst_left > 0) burst_left--;
      else begin
         req_valid <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(0, 4);
      end
   endtask

   // Q16.16 values: mostly in -1.0..1.0, sometimes any pattern
   function logic signed [31:0] near_one();
      if ($urandom_range(0, 15) == 0) return $urandom();
      return $signed($urandom_range(0, 131072)) - 32'sd65536;
   endfunction

   function command_type make_cmd(spb_pkg::cmd_type cmd, int j, int p, int row);
      command_type c;
      c.cmd = cmd;
      c.joint = 6'(j);
      c.parent = 7'(p);
      c.row = 2'(row);
      for (int i = 0; i < 4; i++) c.d[i] = near_one();
      for (int i = 0; i < 3; i++)
         c.t[i] = ($urandom_range(0, 7) == 0) ? $urandom()
                                              : $signed($urandom_range(0, 1 << 21)) - 32'sd1048576;
      return c;
   endfunction

   // Loads whatever the joint still lacks, then poses it
   task pose_joint(int j);
      command_type c;
      int p, k, mode;
      for (int r = 0; r < 4; r++)
         if (!ib_loaded[j][r])
            send(make_cmd(spb_pkg::CMD_LOAD_IB, j, $urandom_range(0, 127), r));
      if (!scale_loaded[j]) send(make_cmd(spb_pkg::CMD_LOAD_SCALE, j, $urandom_range(0, 127),
                                          $urandom_range(0, 3)));
      mode = $urandom_range(0, 9);
      p = -1;
      if (mode == 0) p = -$urandom_range(1, 64);
      else if (mode == 1) p = $urandom_range(j, 63);
      else if (j > 0)
         for (int tries = 0; tries < 8; tries++) begin
            k = $urandom_range(0, j - 1);
            if (posed[k]) begin
               p = k;
               break;
            end
         end
      c = make_cmd(spb_pkg::CMD_POSE, j, p, $urandom_range(0, 3));
      if ($urandom_range(0, 3) == 0) begin
         c.d = '{$urandom(), $urandom(), $urandom(), $urandom()};
         c.t = '{$urandom(), $urandom(), $urandom()};
      end
      send(c);
   endtask

   // Receiver: check on transfer, stall on phases of its own
   int ready_mode = 0;
   int mode_left = 0;
   always @(posedge clock) begin
      palette_row_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.out_row = rsp_out_row;
         got.elem = '{rsp_elem_0, rsp_elem_1, rsp_elem_2, rsp_elem_3};
         got.order_error = rsp_order_error;
         got.saturated = rsp_saturated;
         got.last = rsp_last;
         sb.check_row(got);
      end
      if (mode_left == 0) begin
         ready_mode = $urandom_range(0, 2);
         mode_left = $urandom_range(20, 300);
      end
      else mode_left--;
      case (ready_mode)
         0:       rsp_ready <= 1;
         1:       rsp_ready <= $urandom_range(0, 1);
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   initial begin
      command_type c;
      int cap;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: identity joint, extremes, odd parents, unused command
      for (int r = 0; r < 4; r++) begin
         c = make_cmd(spb_pkg::CMD_LOAD_IB, 0, 0, r);
         c.d = '{0, 0, 0, 0};
         c.d[r] = spb_pkg::ONE_Q;
         send(c);
      end
      c = make_cmd(spb_pkg::CMD_LOAD_SCALE, 0, 0, 0);
      c.d = '{spb_pkg::ONE_Q, spb_pkg::ONE_Q, spb_pkg::ONE_Q, 0};
      send(c);
      c = make_cmd(spb_pkg::CMD_POSE, 0, -1, 0);
      c.d = '{0, 0, 0, spb_pkg::ONE_Q};
      c.t = '{32'sh7fffffff, 32'sh80000000, 0};
      send(c);
      c = make_cmd(spb_pkg::CMD_POSE, 0, -64, 3);
      c.d = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000};
      send(c);
      c = make_cmd(spb_pkg::CMD_POSE, 0, 0, 1);
      c.d = '{0, 0, 0, spb_pkg::ONE_Q};
      send(c);
      c = make_cmd(spb_pkg::CMD_UNUSED, 63, 63, 3);
      c.d = '{-1, -1, -1, -1};
      c.t = '{-1, -1, -1};
      send(c);
      pose_joint(63);
      c = make_cmd(spb_pkg::CMD_POSE, 1, 63, 2);
      pose_joint(1);
      c = make_cmd(spb_pkg::CMD_POSE, 1, 0, 2);
      c.d = '{0, 0, 0, spb_pkg::ONE_Q};
      send(c);
      c = make_cmd(spb_pkg::CMD_POSE, 1, 1, 2);
      send(c);

      // Random: mostly well-formed joint chains, some noise
      while (sent < 470) begin
         case ($urandom_range(0, 9))
            0: send(make_cmd(spb_pkg::CMD_UNUSED, $urandom_range(0, 63),
                             $urandom_range(0, 127) - 64, $urandom_range(0, 3)));
            1: send(make_cmd(spb_pkg::cmd_type'($urandom_range(0, 1)), $urandom_range(0, 63),
                             $urandom_range(0, 127) - 64, $urandom_range(0, 3)));
            2: pose_joint($urandom_range(0, 63));
            default: pose_joint($urandom_range(0, 15));
         endcase
      end
      req_valid <= 0;

      cap = 0;
      while (sb.rows_due.size() != 0 && cap < 200000) begin
         @(posedge clock);
         cap++;
      end
      repeat (300) @(posedge clock);
      $display("sent %0d commands, %0d poses, checked %0d skinning rows",
               sent, sb.poses, sb.rows_checked);
      if (sb.rows_due.size() != 0)
         sb.report("rows never returned", sb.rows_due.size(), 0);
      if (sb.mismatches == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #40ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
